FILE: hdl/wssd_pkg.sv
// Package for the windowed steady-state detector.
// Shared widths, codes, reset values and controller/datapath bundles. No dependencies.
package wssd_pkg;

   localparam int DEFAULT_RING_DEPTH = 64;
   localparam int TIME_W    = 32;
   localparam int FLUX_W    = 32;
   localparam int DEV_W     = 24;
   localparam int HELD_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int DIFF_W    = TIME_W + 2;          // signed time difference
   localparam int PROD_W    = 2 * (TIME_W + 1);    // (f + fprev) * dt
   localparam int ACC_W     = 80;                  // trapezoid sum, never wraps
   localparam int MD_W      = FLUX_W + DIFF_W;     // fmin/fmax times doubled span
   localparam int DEVD_W    = ACC_W + 2;
   localparam int CHUNK_W   = 27;
   localparam int CMP_W     = 106;

   localparam logic [DEV_W-1:0]  ALLOWED_DEV_RESET = 24'd3277;
   localparam logic [TIME_W-1:0] WINDOW_RESET      = 32'd1000;

   typedef enum logic [1:0] {
      VERDICT_CONTINUE   = 2'd0,
      VERDICT_NOT_STEADY = 2'd1,
      VERDICT_STEADY     = 2'd2,
      VERDICT_MEAN_ZERO  = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALLOWED_DEV = 1'd0,
      CSR_WINDOW_SPAN = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic        accept;
      logic        trim_adv;
      logic        span_load;
      logic        scan_start;
      logic        mul_en;
      logic        mul_max;
      logic        dev_load;
      logic        rh_en;
      logic [1:0]  rh_chunk;
      logic        cmp;
      logic        vload;
      verdict_type vcode;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic count_gt2;
      logic lt_win;
      logic gt_win;
      logic diff_pos;
      logic scan_done;
      logic s_zero;
      logic out_full;
   } status_type;

endpackage

FILE: hdl/wssd_channels.sv
// Handshake channel interfaces for the detector: sample requests and verdict responses.
// Depends on wssd_pkg.
interface wssd_req_if;
   logic                         valid;
   logic                         ready;
   logic [wssd_pkg::TIME_W-1:0]  sample_time;
   logic signed [wssd_pkg::FLUX_W-1:0] flux_value;
   modport source (output valid, sample_time, flux_value, input ready);
   modport sink   (input valid, sample_time, flux_value, output ready);
endinterface

interface wssd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   verdict;
   logic [wssd_pkg::HELD_W-1:0]  entries_held;
   logic                         dropped_oldest;
   modport source (output valid, verdict, entries_held, dropped_oldest, input ready);
   modport sink   (input valid, verdict, entries_held, dropped_oldest, output ready);
endinterface

FILE: hdl/wssd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wssd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/wssd_ctrl.sv
// Controller state machine of the detector: sequences append, trim, scan and test.
// Depends on wssd_pkg.
module wssd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  wssd_pkg::status_type status,
   output wssd_pkg::cmd_type    cmd,
   output logic                 idle
);
   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_CHK  = 12'b000000000010,
      ST_TRIM = 12'b000000000100,
      ST_SCAN = 12'b000000001000,
      ST_ZCHK = 12'b000000010000,
      ST_MMAX = 12'b000000100000,
      ST_DEV  = 12'b000001000000,
      ST_RH0  = 12'b000010000000,
      ST_RH1  = 12'b000100000000,
      ST_RH2  = 12'b001000000000,
      ST_CMP  = 12'b010000000000,
      ST_FIN  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      cmd      = '0;
      cmd.vcode = wssd_pkg::VERDICT_CONTINUE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHK;
            end
         end
         ST_CHK: begin
            first_in = 1'b1;
            if (!status.count_gt2) begin
               cmd.vload = 1'b1;
               state_in  = ST_FIN;
            end else begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            first_in = 1'b0;
            if (first_ff && status.lt_win) begin
               cmd.vload = 1'b1;
               state_in  = ST_FIN;
            end else if (status.count_gt2 && status.gt_win) begin
               cmd.trim_adv = 1'b1;
            end else if (!status.diff_pos) begin
               cmd.vload = 1'b1;
               cmd.vcode = wssd_pkg::VERDICT_MEAN_ZERO;
               state_in  = ST_FIN;
            end else begin
               cmd.span_load  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_ZCHK;
            end
         end
         ST_ZCHK: begin
            if (status.s_zero) begin
               cmd.vload = 1'b1;
               cmd.vcode = wssd_pkg::VERDICT_MEAN_ZERO;
               state_in  = ST_FIN;
            end else begin
               cmd.mul_en = 1'b1;
               state_in   = ST_MMAX;
            end
         end
         ST_MMAX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_max = 1'b1;
            state_in    = ST_DEV;
         end
         ST_DEV: begin
            cmd.dev_load = 1'b1;
            state_in     = ST_RH0;
         end
         ST_RH0: begin
            cmd.rh_en    = 1'b1;
            cmd.rh_chunk = 2'd0;
            state_in     = ST_RH1;
         end
         ST_RH1: begin
            cmd.rh_en    = 1'b1;
            cmd.rh_chunk = 2'd1;
            state_in     = ST_RH2;
         end
         ST_RH2: begin
            cmd.rh_en    = 1'b1;
            cmd.rh_chunk = 2'd2;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);
endmodule

FILE: hdl/wssd_datapath.sv
// Datapath of the detector: ring pointers, sample RAM, scan pipeline, wide arithmetic,
// configuration registers and the response register. Depends on wssd_pkg, wssd_ram, channels.
module wssd_datapath #(
   parameter int RING_DEPTH = wssd_pkg::DEFAULT_RING_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wssd_pkg::cmd_type                   cmd,
   output wssd_pkg::status_type                status,
   input  logic [wssd_pkg::TIME_W-1:0]         in_time,
   input  logic signed [wssd_pkg::FLUX_W-1:0]  in_flux,
   input  logic                                csr_we,
   input  logic [wssd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wssd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   wssd_rsp_if.source                          rsp
);
   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int TW = wssd_pkg::TIME_W;
   localparam int FW = wssd_pkg::FLUX_W;
   localparam int DW = wssd_pkg::DIFF_W;
   localparam int AW = wssd_pkg::ACC_W;
   localparam int MW = wssd_pkg::MD_W;
   localparam int VW = wssd_pkg::DEVD_W;
   localparam int KW = wssd_pkg::CHUNK_W;
   localparam int XW = wssd_pkg::CMP_W;
   localparam int PRW = wssd_pkg::PROD_W;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [wssd_pkg::DEV_W-1:0] adev_ff;
   logic [TW-1:0]              win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adev_ff <= wssd_pkg::ALLOWED_DEV_RESET;
         win_ff  <= wssd_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         unique case (wssd_pkg::csr_index_type'(csr_index))
            wssd_pkg::CSR_ALLOWED_DEV: adev_ff <= csr_wdata[wssd_pkg::DEV_W-1:0];
            wssd_pkg::CSR_WINDOW_SPAN: win_ff  <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // ring control
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          drop_ff;
   logic [TW-1:0] newest_ff;
   logic          full;
   logic [PW-1:0] ptr_a, cnt_a, waddr;
   logic [PW:0]   pos_sum;

   assign full    = (cnt_ff == CW'(RING_DEPTH));
   assign ptr_a   = full ? wrap_inc(ptr_ff) : ptr_ff;
   assign cnt_a   = full ? PW'(RING_DEPTH - 1) : cnt_ff[PW-1:0];
   assign pos_sum = {1'b0, ptr_a} + {1'b0, cnt_a};
   assign waddr   = (pos_sum >= (PW+1)'(RING_DEPTH)) ?
                    PW'(pos_sum - (PW+1)'(RING_DEPTH)) : pos_sum[PW-1:0];

   always_comb begin
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         ptr_in = ptr_a;
         cnt_in = CW'(cnt_a) + 1'b1;
      end else if (cmd.trim_adv) begin
         ptr_in = wrap_inc(ptr_ff);
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         drop_ff   <= full;
         newest_ff <= in_time;
      end
   end

   // scan issue side
   logic          act_ff;
   logic [CW-1:0] iss_ff;
   logic [PW-1:0] sadr_ff;
   logic          issue;
   logic          dv_ff, df_ff, pv_ff;
   logic [PW-1:0] raddr;
   logic [TW+FW-1:0] rdata;

   assign issue = act_ff && (iss_ff != cnt_ff);

   always_comb begin
      priority if (act_ff)  raddr = sadr_ff;
      else if (cmd.trim_adv) raddr = wrap_inc(ptr_ff);
      else                   raddr = ptr_ff;
   end

   wssd_ram #(.WIDTH(TW + FW), .DEPTH(RING_DEPTH)) u_ram (
      .clock (clock),
      .we    (cmd.accept),
      .waddr (waddr),
      .wdata ({in_time, in_flux}),
      .raddr (raddr),
      .rdata (rdata)
   );

   logic [TW-1:0]        rd_t;
   logic signed [FW-1:0] rd_f;
   assign rd_t = rdata[TW+FW-1:FW];
   assign rd_f = rdata[FW-1:0];

   // trim compare against the oldest entry
   logic signed [DW-1:0] diff, win_s;
   assign diff  = $signed({2'b00, newest_ff}) - $signed({2'b00, rd_t});
   assign win_s = $signed({2'b00, win_ff});

   logic scan_done;
   assign scan_done = act_ff && !issue && !dv_ff && !pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         dv_ff  <= 1'b0;
         pv_ff  <= 1'b0;
      end else begin
         if (cmd.scan_start)  act_ff <= 1'b1;
         else if (scan_done)  act_ff <= 1'b0;
         dv_ff <= issue;
         pv_ff <= dv_ff && !df_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         iss_ff  <= '0;
         sadr_ff <= ptr_ff;
      end else if (issue) begin
         iss_ff  <= iss_ff + 1'b1;
         sadr_ff <= wrap_inc(sadr_ff);
      end
      df_ff <= (iss_ff == '0);
   end

   // scan compute: min, max, trapezoid product, accumulate
   logic signed [FW-1:0]    fmin_ff, fmax_ff, fprev_ff;
   logic [TW-1:0]           tprev_ff;
   logic signed [FW:0]      fsum;
   logic signed [TW:0]      dt;
   logic signed [PRW-1:0]   prod_ff;
   logic signed [AW-1:0]    s_ff;
   logic signed [DW-1:0]    span_ff;

   assign fsum = FW'(0) + $signed({rd_f[FW-1], rd_f}) + $signed({fprev_ff[FW-1], fprev_ff});
   assign dt   = $signed({1'b0, rd_t}) - $signed({1'b0, tprev_ff});

   always_ff @(posedge clock) begin
      if (cmd.span_load) begin
         span_ff <= diff;
      end
      if (dv_ff) begin
         fprev_ff <= rd_f;
         tprev_ff <= rd_t;
         if (df_ff) begin
            fmin_ff <= rd_f;
            fmax_ff <= rd_f;
         end else begin
            if (rd_f < fmin_ff) fmin_ff <= rd_f;
            if (rd_f > fmax_ff) fmax_ff <= rd_f;
         end
      end
      prod_ff <= fsum * dt;
      if (cmd.scan_start) begin
         s_ff <= '0;
      end else if (pv_ff) begin
         s_ff <= s_ff + AW'(prod_ff);
      end
   end

   // deviation and threshold
   logic signed [MW-1:0]  mind_ff, maxd_ff, mprod;
   logic signed [DW:0]    span2;
   logic signed [FW-1:0]  mop;
   logic signed [VW-1:0]  dlo, dhi, dev_ff;
   logic signed [XW-1:0]  rhs_ff, pp_ext, lhs;
   logic [KW:0]           chunk;
   logic signed [KW+wssd_pkg::DEV_W+1:0] pp;
   logic                  s_neg, lhs_gt, rhs_gt;
   wssd_pkg::verdict_type verdict_ff;

   assign span2 = $signed({span_ff, 1'b0});
   assign mop   = cmd.mul_max ? fmax_ff : fmin_ff;
   assign mprod = MW'(mop * span2);
   assign dlo   = VW'(s_ff) - VW'(mind_ff);
   assign dhi   = VW'(maxd_ff) - VW'(s_ff);

   always_comb begin
      unique case (cmd.rh_chunk)
         2'd0:    chunk = {1'b0, s_ff[KW-1:0]};
         2'd1:    chunk = {1'b0, s_ff[2*KW-1:KW]};
         default: chunk = {{(3*KW-AW+1){s_ff[AW-1]}}, s_ff[AW-1:2*KW]};
      endcase
   end

   assign pp     = $signed(chunk) * $signed({1'b0, adev_ff});
   assign pp_ext = XW'(pp) <<< (KW * cmd.rh_chunk);
   assign lhs    = XW'(dev_ff) <<< 16;
   assign s_neg  = s_ff[AW-1];
   assign lhs_gt = lhs > rhs_ff;
   assign rhs_gt = rhs_ff > lhs;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         if (cmd.mul_max) maxd_ff <= mprod;
         else             mind_ff <= mprod;
      end
      if (cmd.dev_load) begin
         dev_ff <= (dhi > dlo) ? dhi : dlo;
      end
      if (cmd.rh_en) begin
         rhs_ff <= ((cmd.rh_chunk == 2'd0) ? XW'(0) : rhs_ff) + pp_ext;
      end
      if (cmd.vload) begin
         verdict_ff <= cmd.vcode;
      end else if (cmd.cmp) begin
         verdict_ff <= (s_neg ? rhs_gt : lhs_gt) ?
                       wssd_pkg::VERDICT_NOT_STEADY : wssd_pkg::VERDICT_STEADY;
      end
   end

   // response register
   logic       rv_ff;
   logic [1:0] rverdict_ff;
   logic [wssd_pkg::HELD_W-1:0] rheld_ff;
   logic       rdrop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rv_ff <= 1'b1;
      end else if (rsp.ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rverdict_ff <= verdict_ff;
         rheld_ff    <= wssd_pkg::HELD_W'(cnt_ff);
         rdrop_ff    <= drop_ff;
      end
   end

   assign rsp.valid          = rv_ff;
   assign rsp.verdict        = rverdict_ff;
   assign rsp.entries_held   = rheld_ff;
   assign rsp.dropped_oldest = rdrop_ff;

   assign status.count_gt2 = cnt_ff > CW'(2);
   assign status.lt_win    = diff < win_s;
   assign status.gt_win    = diff > win_s;
   assign status.diff_pos  = diff > 0;
   assign status.scan_done = scan_done;
   assign status.s_zero    = (s_ff == '0);
   assign status.out_full  = rv_ff && !rsp.ready;
endmodule

FILE: hdl/windowed_steady_state_detector_core.sv
// Top level of the windowed steady-state detector.
// Depends on wssd_pkg, wssd_channels, wssd_ram, wssd_ctrl and wssd_datapath.
//
// Usage:
//  - req channel: one beat carries sample_time (unsigned ticks, non-decreasing) and
//    flux_value (signed Q16.16). Each beat is appended to a ring of RING_DEPTH entries.
//  - rsp channel: exactly one beat per request: verdict (continue, not steady, steady,
//    mean zero), entries_held after trimming, and dropped_oldest when a full ring lost
//    its oldest sample.
//  - csr port: index 0 allowed_deviation (Q8.16), index 1 window_span (ticks). Write
//    only while no sample is in flight.
// Timing: one sample at a time. A sample that ends early passes the check state (two or
// fewer entries) or also one trim state (span short of the window) before the final
// state, which loads the response register. A full evaluation trims, scans, tests the
// sum for zero, forms the min and max products, the deviation and the threshold: the
// trim and the scan each read one RAM entry per cycle through the single read port, and
// the threshold product runs as three 27x24 partial products.
// Reset clears the ring pointer and count (ring contents are left as they are) and
// loads the register defaults.
// Stall: a finished response waits in the output register; the next sample is taken
// meanwhile and its evaluation holds in a final state until the register frees up.
module windowed_steady_state_detector_core #(
   parameter int RING_DEPTH = wssd_pkg::DEFAULT_RING_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wssd_req_if.sink                             req_chan,
   wssd_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [wssd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wssd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   wssd_pkg::cmd_type    cmd;
   wssd_pkg::status_type status;
   logic                 idle;
   logic                 req_fire;

   // accept a beat only while the controller waits for work
   assign req_chan.ready = idle;
   assign req_fire       = req_chan.valid && idle;

   wssd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .status   (status),
      .cmd      (cmd),
      .idle     (idle)
   );

   wssd_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_time   (req_chan.sample_time),
      .in_flux   (req_chan.flux_value),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_chan)
   );
endmodule

FILE: dv/windowed_steady_state_detector_core_test.sv
// Self-checking testbench for windowed_steady_state_detector_core.
// Depends on wssd_pkg and the wssd_req_if / wssd_rsp_if interfaces of the RTL.
// Feeds timestamped flux samples, predicts each verdict with an exact wide-integer model.
module windowed_steady_state_detector_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = wssd_pkg::DEFAULT_RING_DEPTH;

   typedef struct {
      logic [wssd_pkg::TIME_W-1:0] t;
      logic [wssd_pkg::FLUX_W-1:0] f;
   } sample_beat_type;

   typedef struct {
      wssd_pkg::verdict_type       verdict;
      logic [wssd_pkg::HELD_W-1:0] held;
      logic                        dropped;
   } verdict_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [wssd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [wssd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   wssd_req_if req_chan();
   wssd_rsp_if rsp_chan();

   windowed_steady_state_detector_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: our own copy of the ring, its pointer and count, and the registers.
   logic [wssd_pkg::TIME_W-1:0] ring_time [DEPTH];
   logic [wssd_pkg::FLUX_W-1:0] ring_flux [DEPTH];
   int                          ring_head;
   int                          ring_count;
   logic [wssd_pkg::DEV_W-1:0]  dev_limit  = wssd_pkg::ALLOWED_DEV_RESET;
   logic [wssd_pkg::TIME_W-1:0] span_ticks = wssd_pkg::WINDOW_RESET;

   sample_beat_type  pending_samples[$];
   verdict_beat_type awaited_verdicts[$];

   int  mismatches = 0;
   int  verdict_seen [4] = '{0, 0, 0, 0};
   int  drops_seen = 0;
   bit  idle_on = 1'b1;
   bit  long_hold_req = 1'b0;
   bit  req_acc;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   logic [wssd_pkg::TIME_W-1:0] cur_time = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint tick_at(int k);
      return longint'(ring_time[(ring_head + k) % DEPTH]);
   endfunction

   // Append one sample, trim the window and classify it exactly.
   function automatic verdict_beat_type classify_sample(sample_beat_type s);
      verdict_beat_type e;
      longint newest, span, t, tprev, f, fprev, fmin, fmax;
      logic signed [127:0] acc, mind, maxd, devd, lhs, rhs, a, b;
      e.dropped = 1'b0;
      if (ring_count >= DEPTH) begin
         ring_head  = (ring_head + 1) % DEPTH;
         ring_count = DEPTH - 1;
         e.dropped  = 1'b1;
      end
      ring_time[(ring_head + ring_count) % DEPTH] = s.t;
      ring_flux[(ring_head + ring_count) % DEPTH] = s.f;
      ring_count++;
      newest = tick_at(ring_count - 1);
      if (ring_count <= 2 || newest - tick_at(0) < longint'(span_ticks)) begin
         e.verdict = wssd_pkg::VERDICT_CONTINUE;
      end else begin
         // drop entries older than the window, keep at least two
         while (ring_count > 2 && newest - tick_at(0) > longint'(span_ticks)) begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
         end
         span = newest - tick_at(0);
         if (span <= 0) begin
            e.verdict = wssd_pkg::VERDICT_MEAN_ZERO;
         end else begin
            fprev = longint'($signed(ring_flux[ring_head]));
            fmin = fprev;
            fmax = fprev;
            tprev = tick_at(0);
            acc = '0;
            for (int k = 1; k < ring_count; k++) begin
               f = longint'($signed(ring_flux[(ring_head + k) % DEPTH]));
               t = tick_at(k);
               if (f < fmin) fmin = f;
               if (f > fmax) fmax = f;
               a = f + fprev;
               b = t - tprev;
               acc += a * b;
               fprev = f;
               tprev = t;
            end
            if (acc == 0) begin
               e.verdict = wssd_pkg::VERDICT_MEAN_ZERO;
            end else begin
               b = 2 * span;
               a = fmin;
               mind = a * b;
               a = fmax;
               maxd = a * b;
               devd = acc - mind;
               if (maxd - acc > devd) devd = maxd - acc;
               lhs = devd * 128'sd65536;
               rhs = acc * $signed({104'b0, dev_limit});
               if (acc > 0)
                  e.verdict = (lhs > rhs) ? wssd_pkg::VERDICT_NOT_STEADY
                                          : wssd_pkg::VERDICT_STEADY;
               else
                  e.verdict = (rhs > lhs) ? wssd_pkg::VERDICT_NOT_STEADY
                                          : wssd_pkg::VERDICT_STEADY;
            end
         end
      end
      e.held = wssd_pkg::HELD_W'(ring_count);
      return e;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Monitor: sample both handshakes at the rising edge.
   always @(posedge clock) begin
      verdict_beat_type e;
      sample_beat_type  s;
      req_acc = !reset && req_chan.valid && req_chan.ready;
      if (req_acc) begin
         s.t = req_chan.sample_time;
         s.f = req_chan.flux_value;
         awaited_verdicts.push_back(classify_sample(s));
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_verdicts.size() == 0) begin
            report_mismatch("unexpected beat, verdict", rsp_chan.verdict, -1);
         end else begin
            e = awaited_verdicts.pop_front();
            if (rsp_chan.verdict !== e.verdict)
               report_mismatch("verdict", rsp_chan.verdict, e.verdict);
            if (rsp_chan.entries_held !== e.held)
               report_mismatch("entries_held", rsp_chan.entries_held, e.held);
            if (rsp_chan.dropped_oldest !== e.dropped)
               report_mismatch("dropped_oldest", rsp_chan.dropped_oldest, e.dropped);
            verdict_seen[e.verdict]++;
            if (e.dropped) drops_seen++;
         end
      end
   end

   // Driver: advance the request channel at the falling edge.
   always @(negedge clock) begin
      sample_beat_type s;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_acc) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            req_chan.sample_time <= s.t;
            req_chan.flux_value  <= s.f;
            req_chan.valid       <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 16);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus one long hold to back the block up.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 600;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.sample_time = '0;
      req_chan.flux_value = '0;
      rsp_chan.ready = 1'b0;
      ring_head = 0;
      ring_count = 0;
   end

   task automatic push_sample(logic [wssd_pkg::TIME_W-1:0] t,
                              logic [wssd_pkg::FLUX_W-1:0] f);
      sample_beat_type s;
      s.t = t;
      s.f = f;
      pending_samples.push_back(s);
      cur_time = t;
   endtask

   // Write one register while the block is idle; the predictor follows along.
   task automatic write_csr(wssd_pkg::csr_index_type idx,
                            logic [wssd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == wssd_pkg::CSR_ALLOWED_DEV) dev_limit = value[wssd_pkg::DEV_W-1:0];
      else                                  span_ticks = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued sample went in and every verdict came back, then settle.
   task automatic drain();
      wait (pending_samples.size() == 0 && !req_chan.valid);
      wait (awaited_verdicts.size() == 0);
      repeat (150) @(posedge clock);
   endtask

   // Mostly near-constant flux runs with random steps; some noise and stray times.
   task automatic add_random(int n, longint max_dt);
      int  seg = 0;
      int  noise = 0;
      logic signed [31:0] base = 0;
      logic [wssd_pkg::TIME_W-1:0] t;
      logic signed [31:0] f;
      for (int i = 0; i < n; i++) begin
         if (seg == 0) begin
            seg = $urandom_range(8, 40);
            base = $urandom;
            if ($urandom_range(0, 2) == 0) base = base >>> $urandom_range(0, 16);
            case ($urandom_range(0, 3))
               0: noise = 0;
               1: noise = 1 << $urandom_range(0, 8);
               2: noise = 1 << $urandom_range(8, 20);
               default: noise = 1 << $urandom_range(20, 28);
            endcase
         end
         seg--;
         t = cur_time + wssd_pkg::TIME_W'($urandom_range(0, int'(max_dt)));
         f = base + $signed($urandom_range(0, 2 * noise)) - noise;
         case ($urandom_range(0, 39))
            0: t = $urandom;
            1: f = $urandom;
            default: ;
         endcase
         push_sample(t, f);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero mean, steady, not steady, negative mean, extremes, backward time.
      push_sample(32'd0, 32'd0);
      push_sample(32'd500, 32'd0);
      push_sample(32'd1000, 32'd0);
      push_sample(32'd1600, 32'h0001_0000);
      push_sample(32'd2200, 32'h0001_0000);
      push_sample(32'd2800, 32'h0001_0000);
      push_sample(32'd3400, 32'h0009_0000);
      push_sample(32'd4000, 32'hFFF0_0000);
      push_sample(32'd4600, 32'hFFF0_0000);
      push_sample(32'd5200, 32'hFFF0_0000);
      push_sample(32'd5800, 32'h7FFF_FFFF);
      push_sample(32'd6400, 32'h8000_0000);
      push_sample(32'd7000, 32'h7FFF_FFFF);
      push_sample(32'd7000, 32'h7FFF_FFFF);
      push_sample(32'd3000, 32'h0000_0001);
      push_sample(32'd9000, 32'h0000_0001);
      push_sample(32'd9000, 32'h0000_0001);
      push_sample(32'hFFFF_FFFF, 32'h8000_0000);
      push_sample(32'hFFFF_FFFF, 32'h8000_0000);
      push_sample(32'hFFFF_FFFF, 32'h0000_0000);
      add_random(100, 400);
      drain();

      write_csr(wssd_pkg::CSR_ALLOWED_DEV, 32'd0);
      write_csr(wssd_pkg::CSR_WINDOW_SPAN, 32'd1);
      add_random(120, 4);
      drain();

      // Huge window: never reaches the span, so the ring fills and drops.
      write_csr(wssd_pkg::CSR_ALLOWED_DEV, 32'h00FF_FFFF);
      write_csr(wssd_pkg::CSR_WINDOW_SPAN, 32'hFFFF_FFFF);
      cur_time = $urandom;
      add_random(120, 1 << 20);
      drain();

      // Window wider than the ring: fill it, and back the block up with a long hold.
      write_csr(wssd_pkg::CSR_ALLOWED_DEV, 32'd3277);
      write_csr(wssd_pkg::CSR_WINDOW_SPAN, 32'd300);
      cur_time = '0;
      add_random(150, 3);
      @(posedge clock);
      long_hold_req = 1'b1;
      drain();

      write_csr(wssd_pkg::CSR_ALLOWED_DEV, 32'd65536);
      write_csr(wssd_pkg::CSR_WINDOW_SPAN, 32'd200);
      add_random(150, 40);
      drain();

      // Final stretch without idling on either side.
      write_csr(wssd_pkg::CSR_ALLOWED_DEV, 32'd655);
      write_csr(wssd_pkg::CSR_WINDOW_SPAN, 32'd1000);
      idle_on = 1'b0;
      add_random(150, 200);
      drain();

      $display("Covered %0d continue, %0d not steady, %0d steady, %0d mean zero verdicts,",
               verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
      $display("with %0d full-ring drops, over six register settings.", drops_seen);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: windowed_steady_state_detector_core.f
hdl/wssd_pkg.sv
hdl/wssd_channels.sv
hdl/wssd_ram.sv
hdl/wssd_ctrl.sv
hdl/wssd_datapath.sv
hdl/windowed_steady_state_detector_core.sv
dv/windowed_steady_state_detector_core_test.sv
